### rtl/core/xee_pkg.sv
// ----------------------------------------------------------------------------
// xee_pkg
// Shared types, character codes and run-building functions for the XML
// entity escaper.
// ----------------------------------------------------------------------------
package xee_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned PosW   = 3;   // position within a run, 0..5

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_HEX,
    KIND_LT,
    KIND_GT,
    KIND_AMP,
    KIND_QUOT,
    KIND_APOS
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_LT   = 8'h3c;
  localparam logic [7:0] CH_GT   = 8'h3e;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_L    = 8'h6c;
  localparam logic [7:0] CH_M    = 8'h6d;
  localparam logic [7:0] CH_O    = 8'h6f;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_Q    = 8'h71;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_U    = 8'h75;

  localparam logic [6:0] CtrlLimit = 7'h20;

  function automatic logic [PosW-1:0] run_len(kind_e kind);
    logic [PosW-1:0] len;
    case (kind)
      KIND_PASS: len = 3'd1;
      KIND_HEX:  len = 3'd3;
      KIND_LT:   len = 3'd4;
      KIND_GT:   len = 3'd4;
      KIND_AMP:  len = 3'd5;
      KIND_QUOT: len = 3'd6;
      KIND_APOS: len = 3'd6;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'd0, nib};
    end else begin
      c = CH_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

  // Character at position pos of the entity name (between '&' and ';').
  function automatic logic [7:0] name_char(kind_e kind, logic [1:0] pos);
    logic [7:0] c;
    c = CH_T;
    case (kind)
      KIND_LT:   c = (pos == 2'd0) ? CH_L : CH_T;
      KIND_GT:   c = (pos == 2'd0) ? CH_G : CH_T;
      KIND_AMP: begin
        case (pos)
          2'd0:    c = CH_A;
          2'd1:    c = CH_M;
          default: c = CH_P;
        endcase
      end
      KIND_QUOT: begin
        case (pos)
          2'd0:    c = CH_Q;
          2'd1:    c = CH_U;
          2'd2:    c = CH_O;
          default: c = CH_T;
        endcase
      end
      KIND_APOS: begin
        case (pos)
          2'd0:    c = CH_A;
          2'd1:    c = CH_P;
          2'd2:    c = CH_O;
          default: c = CH_S;
        endcase
      end
      default:   c = CH_T;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] run_byte(cmd_t cmd, logic [PosW-1:0] idx);
    logic [7:0]      c;
    logic [PosW-1:0] npos;
    npos = idx - 3'd1;
    case (cmd.kind)
      KIND_PASS: c = cmd.data;
      KIND_HEX: begin
        case (idx)
          3'd0:    c = CH_PCT;
          3'd1:    c = hex_char(cmd.data[7:4]);
          default: c = hex_char(cmd.data[3:0]);
        endcase
      end
      default: begin
        if (idx == 3'd0) begin
          c = CH_AMP;
        end else if (idx == run_len(cmd.kind) - 3'd1) begin
          c = CH_SEMI;
        end else begin
          c = name_char(cmd.kind, npos[1:0]);
        end
      end
    endcase
    return c;
  endfunction

endpackage

### rtl/core/xee_front.sv
// ----------------------------------------------------------------------------
// xee_front
// Accepts input bytes and classifies each into a run command for the queue.
// ----------------------------------------------------------------------------
module xee_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  xee_pkg::q_status_t q_status_i,
  output logic              push_o,
  output xee_pkg::cmd_t     cmd_o
);
  import xee_pkg::*;

  kind_e kind;

  always_comb begin
    if (in_byte_i inside {CH_LT}) begin
      kind = KIND_LT;
    end else if (in_byte_i inside {CH_GT}) begin
      kind = KIND_GT;
    end else if (in_byte_i inside {CH_AMP}) begin
      kind = KIND_AMP;
    end else if (in_byte_i inside {CH_DQ}) begin
      kind = KIND_QUOT;
    end else if (in_byte_i inside {CH_SQ}) begin
      kind = KIND_APOS;
    end else if ((in_byte_i[6:0] < CtrlLimit) || (in_byte_i == CH_PCT)) begin
      kind = KIND_HEX;   // control bytes and the percent sign itself
    end else begin
      kind = KIND_PASS;
    end
  end

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;
  assign cmd_o.kind = kind;
  assign cmd_o.data = in_byte_i;

endmodule

### rtl/core/xee_queue.sv
// ----------------------------------------------------------------------------
// xee_queue
// Short command queue between the classifier and the run serializer.
// ----------------------------------------------------------------------------
module xee_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  xee_pkg::cmd_t      push_cmd_i,
  input  logic               pop_i,
  output xee_pkg::cmd_t      head_o,
  output xee_pkg::q_status_t status_o
);
  import xee_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QIdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QIdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == QCntW'(QDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != QCntW'(QDepth)) |-> (wr_ptr_q - rd_ptr_q == count_q[QIdxW-1:0]))
    else $error("queue pointers disagree with count");

endmodule

### rtl/core/xee_back.sv
// ----------------------------------------------------------------------------
// xee_back
// Walks the head command byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module xee_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xee_pkg::cmd_t      head_i,
  input  xee_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o
);
  import xee_pkg::*;

  logic [PosW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            run_last_q;
  logic            load;
  logic            is_last;

  // Output slot is free when empty or being taken this cycle.
  assign load    = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == run_len(head_i.kind) - 3'd1);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = is_last ? '0 : idx_q + 3'd1;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= run_byte(head_i, idx_q);
      run_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status_i.empty |-> (idx_q == '0))
    else $error("run position left nonzero with no command");

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> (idx_q < run_len(head_i.kind)))
    else $error("run position past end of run");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && run_last_q))
    else $error("command retired without a final byte");

endmodule

### rtl/core/xml_entity_escaper_core.sv
// ----------------------------------------------------------------------------
// xml_entity_escaper_core
// Escapes a byte stream for XML: markup characters become named entities,
// control bytes and '%' become %hh, all others pass through.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------
//  in      | in_valid_i  | in_stall_o  | in_byte_i
//  out     | out_valid_o | out_stall_i | out_byte_o, run_last_o
//
//  An item produces a run of 1 to 6 output bytes, one byte per cycle while
//  out_stall_i is low; the serializer takes the next queued item only after
//  the last byte of a run, and pass-through bytes sustain one item per cycle
//  while out_stall_i is low. An accepted byte passes the command queue and
//  then the output register before its first output byte is valid.
//  A 4-entry command queue lets input keep flowing while a run drains or the
//  output stalls; in_stall_o rises only when that queue is full.
//  Reset empties queue and output register, zeroes run index; no other state.
module xml_entity_escaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);
  import xee_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      head;
  logic      push;
  logic      pop;

  xee_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  xee_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  xee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule
